// ===== hdl/jsu_pkg.sv =====
// Types, character codes and decode functions for the JSON string unescape core.
package jsu_pkg;

   localparam int HOLD_DEPTH = 12;
   localparam int HOLD_IDX_W = 4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       buffer_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_end;
      logic [1:0] end_reason;
      logic       run_last;
   } rsp_type;

   typedef enum logic [0:0] {
      SCAN_SEEK,
      SCAN_STRING
   } scan_type;

   localparam logic [1:0] END_QUOTE    = 2'd0;
   localparam logic [1:0] END_BUFFER   = 2'd1;
   localparam logic [1:0] END_NO_QUOTE = 2'd2;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_R  = 8'h72;

   localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
   localparam logic [20:0] CP_SUPPL   = 21'h010000;
   localparam logic [15:0] HI_FIRST   = 16'hD800;
   localparam logic [15:0] HI_LAST    = 16'hDBFF;
   localparam logic [15:0] LO_FIRST   = 16'hDC00;
   localparam logic [15:0] LO_LAST    = 16'hDFFF;

   // Byte 0 is the oldest held byte.
   typedef logic [HOLD_DEPTH-1:0][7:0] hold_type;

   typedef struct packed {
      logic        bad;
      logic        short_grp;
      logic [15:0] value;
   } grp_type;

   typedef struct packed {
      logic                  need_more;
      logic                  quote;
      logic                  silent;
      logic                  raw;
      logic [20:0]           cp;
      logic [HOLD_IDX_W-1:0] drop;
   } tok_type;

   function automatic logic is_hex(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(logic [7:0] c);
      return (c <= 8'h39) ? c[3:0] : 4'(c[3:0] + 4'd9);
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   // Four hex digits starting at a fixed place; only held bytes count.
   function automatic grp_type hex_group(hold_type h, int unsigned start,
                                         logic [HOLD_IDX_W-1:0] len);
      grp_type g;
      logic    present;
      g = '0;
      for (int unsigned i = 0; i < 4; i++) begin
         present = len > HOLD_IDX_W'(start + i);
         if (present && !is_hex(h[HOLD_IDX_W'(start + i)])) g.bad = 1'b1;
         if (!present) g.short_grp = 1'b1;
         g.value = {g.value[11:0], hex_val(h[HOLD_IDX_W'(start + i)])};
      end
      if (g.bad) g.short_grp = 1'b0;
      return g;
   endfunction

   // Decide the token at the head of the held bytes.
   function automatic tok_type tok_decide(hold_type h, logic [HOLD_IDX_W-1:0] len,
                                          logic at_end);
      tok_type     t;
      grp_type     g1;
      grp_type     g2;
      logic        bad;
      logic        complete;
      t  = '0;
      g1 = hex_group(h, 2, len);
      g2 = hex_group(h, 8, len);
      bad = (len > HOLD_IDX_W'(6) && h[6] != CH_BSLASH) ||
            (len > HOLD_IDX_W'(7) && h[7] != CH_LOW_U) || g2.bad;
      complete = len == HOLD_IDX_W'(HOLD_DEPTH);
      if (h[0] == CH_QUOTE) begin
         t.quote = 1'b1;
      end else if (h[0] != CH_BSLASH) begin
         t.raw  = 1'b1;
         t.cp   = {13'd0, h[0]};
         t.drop = HOLD_IDX_W'(1);
      end else if (len < HOLD_IDX_W'(2)) begin
         // lone backslash: drop it at buffer end, else wait for the next byte
         if (at_end) begin
            t.silent = 1'b1;
            t.drop   = HOLD_IDX_W'(1);
         end else begin
            t.need_more = 1'b1;
         end
      end else if (h[1] != CH_LOW_U) begin
         t.raw  = 1'b1;
         t.drop = HOLD_IDX_W'(2);
         case (h[1])
            CH_LOW_B: t.cp = {13'd0, CH_BS};
            CH_LOW_F: t.cp = {13'd0, CH_FF};
            CH_LOW_N: t.cp = {13'd0, CH_LF};
            CH_LOW_T: t.cp = {13'd0, CH_TAB};
            CH_LOW_R: t.cp = {13'd0, CH_CR};
            default:  t.cp = {13'd0, h[1]};
         endcase
      end else if (g1.short_grp && !at_end) begin
         t.need_more = 1'b1;
      end else if (g1.bad || g1.short_grp) begin
         t.cp   = CP_REPLACE;
         t.drop = HOLD_IDX_W'(2);
      end else if (g1.value >= HI_FIRST && g1.value <= HI_LAST) begin
         if (!bad && !complete && !at_end) begin
            t.need_more = 1'b1;
         end else if (!bad && complete && g2.value >= LO_FIRST && g2.value <= LO_LAST) begin
            t.cp   = CP_SUPPL + {1'b0, g1.value[9:0], g2.value[9:0]};
            t.drop = HOLD_IDX_W'(12);
         end else begin
            t.cp   = CP_REPLACE;
            t.drop = HOLD_IDX_W'(6);
         end
      end else if (g1.value >= LO_FIRST && g1.value <= LO_LAST) begin
         t.cp   = CP_REPLACE;
         t.drop = HOLD_IDX_W'(6);
      end else begin
         t.cp   = {5'd0, g1.value};
         t.drop = HOLD_IDX_W'(6);
      end
      return t;
   endfunction

   function automatic hold_type hold_shift(hold_type h, logic [HOLD_IDX_W-1:0] n);
      return h >> {n, 3'b000};
   endfunction

   // Index of the last UTF-8 byte for a code point.
   function automatic logic [1:0] utf8_last(logic [20:0] cp);
      if (cp <= 21'h7F) return 2'd0;
      if (cp <= 21'h7FF) return 2'd1;
      if (cp <= 21'hFFFF) return 2'd2;
      return 2'd3;
   endfunction

   function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [1:0] idx);
      logic [7:0] b;
      b = cp[7:0];
      case (utf8_last(cp))
         2'd1: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         2'd2: begin
            case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         2'd3: begin
            case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: b = cp[7:0];
      endcase
      return b;
   endfunction

endpackage

// ===== hdl/json_string_unescape_utf8_core.sv =====
// JSON string value decoder: text bytes in, unescaped UTF-8 bytes and end marks out.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_data : req_type (text_byte, buffer_last)
//   rsp      out        rsp_valid / rsp_ready   rsp_data : rsp_type (one result per transfer)
//
// One result leaves the decode stage per cycle while the skid is empty; a \u escape
// yields one result per UTF-8 byte (up to four); bytes after a failed escape are rescanned.
// The next request is taken in the cycle that produces the last result of the current one.
// Reset (synchronous) returns to seeking the opening quote with empty hold and output stages.
// A low rsp_ready fills the two-entry output stage, stalling decode; req_ready drops if busy.
module json_string_unescape_utf8_core
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   scan_type              mode_ff, mode_in;
   hold_type              hold_ff, hold_in, hold_work;
   logic [HOLD_IDX_W-1:0] count_ff, count_in, count_work;
   logic                  busy_ff, busy_in;
   logic                  at_end_ff, at_end_in;
   logic [1:0]            idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  skid_valid_ff, skid_valid_in;
   rsp_type               skid_ff, skid_in;

   tok_type               tok, rem_tok;
   hold_type              rem_hold;
   logic [HOLD_IDX_W-1:0] rem_len;
   logic                  rem_idle;
   logic                  go, done, final_byte, accept, push;
   rsp_type               push_data;
   logic [1:0]            last_idx;

   assign tok      = tok_decide(hold_ff, count_ff, at_end_ff);
   assign rem_hold = hold_shift(hold_ff, tok.drop);
   assign rem_len  = count_ff - tok.drop;
   assign rem_tok  = tok_decide(rem_hold, rem_len, 1'b0);
   // what is left after this token yields nothing until more text arrives
   assign rem_idle = (rem_len == '0) || rem_tok.need_more;
   assign last_idx = tok.raw ? 2'd0 : utf8_last(tok.cp);

   assign go        = busy_ff && !skid_valid_ff;
   assign req_ready = !busy_ff || done;
   assign accept    = req_valid && req_ready;

   always_comb begin
      mode_in    = mode_ff;
      hold_work  = hold_ff;
      count_work = count_ff;
      idx_in     = idx_ff;
      done       = 1'b0;
      push       = 1'b0;
      push_data  = '0;
      final_byte = tok.silent || (idx_ff == last_idx);
      if (go) begin
         unique case (mode_ff)
            SCAN_SEEK: begin
               count_work = '0;
               done       = 1'b1;
               if (is_space(hold_ff[0])) begin
                  if (at_end_ff) begin
                     push                 = 1'b1;
                     push_data.string_end = 1'b1;
                     push_data.end_reason = END_NO_QUOTE;
                  end
               end else if (hold_ff[0] == CH_QUOTE) begin
                  if (at_end_ff) begin
                     push                 = 1'b1;
                     push_data.string_end = 1'b1;
                     push_data.end_reason = END_BUFFER;
                  end else begin
                     mode_in = SCAN_STRING;
                  end
               end else begin
                  push                 = 1'b1;
                  push_data.string_end = 1'b1;
                  push_data.end_reason = END_NO_QUOTE;
               end
            end
            SCAN_STRING: begin
               if (count_ff == '0) begin
                  // hold drained at buffer end
                  push                 = 1'b1;
                  push_data.string_end = 1'b1;
                  push_data.end_reason = END_BUFFER;
                  mode_in              = SCAN_SEEK;
                  done                 = 1'b1;
               end else if (tok.quote) begin
                  push                 = 1'b1;
                  push_data.string_end = 1'b1;
                  push_data.end_reason = END_QUOTE;
                  mode_in              = SCAN_SEEK;
                  count_work           = '0;
                  done                 = 1'b1;
               end else if (tok.need_more) begin
                  done = 1'b1;
               end else begin
                  if (!tok.silent) begin
                     push                 = 1'b1;
                     push_data.byte_valid = 1'b1;
                     push_data.out_byte   = tok.raw ? tok.cp[7:0] : utf8_byte(tok.cp, idx_ff);
                  end
                  if (final_byte) begin
                     hold_work  = rem_hold;
                     count_work = rem_len;
                     idx_in     = 2'd0;
                     done       = !at_end_ff && rem_idle;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end
            end
            default: begin
               mode_in = SCAN_SEEK;
            end
         endcase
      end
      push_data.run_last = done;
   end

   always_comb begin
      hold_in   = hold_work;
      count_in  = count_work;
      at_end_in = at_end_ff;
      busy_in   = busy_ff;
      if (done) busy_in = 1'b0;
      if (accept) begin
         busy_in   = 1'b1;
         at_end_in = req_data.buffer_last;
         if (count_work < HOLD_IDX_W'(HOLD_DEPTH)) begin
            hold_in[count_work] = req_data.text_byte;
            count_in            = count_work + HOLD_IDX_W'(1);
         end
      end
   end

   // two-entry output stage: head register plus skid register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (!rsp_valid_in && skid_valid_in) begin
         rsp_in        = skid_ff;
         rsp_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (!rsp_valid_in) begin
            rsp_in       = push_data;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= SCAN_SEEK;
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         at_end_ff     <= 1'b0;
         idx_ff        <= 2'd0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         at_end_ff     <= at_end_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
